FILE: rtl/mf_pkg.sv
// ----------------------------------------------------------------------------
// Median filter package
// Shared types, the 5x5 sorting network and the stage functions.
// ----------------------------------------------------------------------------
package mf_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int NET25_OPS   = 97;
    localparam int OPS_PER_STG = 4;
    localparam int NET_STAGES  = (NET25_OPS + OPS_PER_STG - 1) / OPS_PER_STG;

    localparam logic [1:0] OP_CS  = 2'd0;
    localparam logic [1:0] OP_MIN = 2'd1;
    localparam logic [1:0] OP_MAX = 2'd2;

    localparam logic       REG_IDX_MASK  = 1'b0;
    localparam logic       REG_IDX_WIDTH = 1'b1;

    typedef logic signed [SAMPLE_BITS-1:0] t_smp;
    typedef t_smp [24:0] t_win;
    typedef t_smp [8:0]  t_nine;

    typedef struct packed {
        t_smp pixel;
        logic frame_start;
    } t_pix;

    typedef struct packed {
        t_smp median;
        logic row_end;
    } t_res;

    typedef struct packed {
        t_win win;
        logic m5;
        logic last;
    } t_qent;

    typedef struct packed {
        logic push;
        logic pop;
        logic full;
        logic empty;
    } t_qstat;

    localparam logic [11:0] NET25 [0:NET25_OPS-1] = '{
        {OP_CS,5'd0,5'd1},
        {OP_CS,5'd3,5'd4},   {OP_CS,5'd2,5'd4},   {OP_CS,5'd2,5'd3},
        {OP_CS,5'd6,5'd7},   {OP_CS,5'd5,5'd7},   {OP_CS,5'd5,5'd6},
        {OP_CS,5'd2,5'd5},
        {OP_CS,5'd3,5'd6},   {OP_CS,5'd0,5'd6},   {OP_CS,5'd0,5'd3},
        {OP_CS,5'd4,5'd7},   {OP_CS,5'd1,5'd7},   {OP_CS,5'd1,5'd4},
        {OP_CS,5'd9,5'd10},  {OP_CS,5'd8,5'd10},  {OP_CS,5'd8,5'd9},
        {OP_CS,5'd12,5'd13}, {OP_CS,5'd11,5'd13}, {OP_CS,5'd11,5'd12},
        {OP_CS,5'd15,5'd16}, {OP_CS,5'd14,5'd16}, {OP_CS,5'd14,5'd15},
        {OP_CS,5'd11,5'd14}, {OP_CS,5'd8,5'd14},  {OP_CS,5'd8,5'd11},
        {OP_CS,5'd13,5'd16}, {OP_CS,5'd10,5'd16}, {OP_CS,5'd10,5'd13},
        {OP_CS,5'd18,5'd19}, {OP_CS,5'd17,5'd19}, {OP_CS,5'd17,5'd18},
        {OP_CS,5'd21,5'd22}, {OP_CS,5'd20,5'd22}, {OP_CS,5'd20,5'd21},
        {OP_CS,5'd23,5'd24},
        {OP_CS,5'd20,5'd23}, {OP_CS,5'd17,5'd23}, {OP_CS,5'd17,5'd20},
        {OP_CS,5'd21,5'd24}, {OP_CS,5'd18,5'd24}, {OP_CS,5'd18,5'd21},
        {OP_CS,5'd19,5'd22},
        {OP_MAX,5'd17,5'd8},
        {OP_CS,5'd9,5'd18},  {OP_CS,5'd0,5'd18},  {OP_CS,5'd0,5'd9},
        {OP_MAX,5'd9,5'd0},
        {OP_CS,5'd10,5'd19}, {OP_CS,5'd1,5'd19},  {OP_CS,5'd1,5'd10},
        {OP_CS,5'd11,5'd20}, {OP_CS,5'd2,5'd20},  {OP_MAX,5'd11,5'd2},
        {OP_CS,5'd12,5'd21}, {OP_CS,5'd3,5'd21},  {OP_CS,5'd3,5'd12},
        {OP_CS,5'd13,5'd22}, {OP_CS,5'd4,5'd22},  {OP_MIN,5'd4,5'd22},
        {OP_CS,5'd4,5'd13},
        {OP_CS,5'd14,5'd23}, {OP_CS,5'd5,5'd23},  {OP_CS,5'd5,5'd14},
        {OP_CS,5'd15,5'd24}, {OP_MIN,5'd6,5'd24}, {OP_CS,5'd6,5'd15},
        {OP_MIN,5'd7,5'd16}, {OP_MIN,5'd7,5'd19},
        {OP_MIN,5'd13,5'd21},{OP_MIN,5'd15,5'd23},
        {OP_MIN,5'd7,5'd13}, {OP_MIN,5'd7,5'd15},
        {OP_MAX,5'd9,5'd1},  {OP_MAX,5'd11,5'd3},
        {OP_MAX,5'd17,5'd5}, {OP_MAX,5'd17,5'd11},{OP_MAX,5'd17,5'd9},
        {OP_CS,5'd4,5'd10},  {OP_CS,5'd6,5'd12},  {OP_CS,5'd7,5'd14},
        {OP_CS,5'd4,5'd6},   {OP_MAX,5'd7,5'd4},
        {OP_CS,5'd12,5'd14}, {OP_MIN,5'd10,5'd14},
        {OP_CS,5'd6,5'd7},   {OP_CS,5'd10,5'd12}, {OP_CS,5'd6,5'd10},
        {OP_MAX,5'd17,5'd6},
        {OP_CS,5'd12,5'd17}, {OP_MIN,5'd7,5'd17},
        {OP_CS,5'd7,5'd10},  {OP_CS,5'd12,5'd18},
        {OP_MAX,5'd12,5'd7}, {OP_MIN,5'd10,5'd18},
        {OP_CS,5'd12,5'd20}, {OP_MIN,5'd10,5'd20}
    };

    function automatic t_smp smp_min(t_smp a, t_smp b);
        return (a < b) ? a : b;
    endfunction

    function automatic t_smp smp_max(t_smp a, t_smp b);
        return (a > b) ? a : b;
    endfunction

    function automatic t_smp med3(t_smp a, t_smp b, t_smp c);
        return smp_min(smp_max(a, smp_min(b, c)), smp_max(b, c));
    endfunction

    function automatic t_win net25_stage(t_win vin, int stg);
        t_win        v;
        logic [11:0] op;
        t_smp        lo;
        t_smp        hi;
        int          idx;
        v = vin;
        for (int j = 0; j < OPS_PER_STG; j++) begin
            idx = stg * OPS_PER_STG + j;
            if (idx < NET25_OPS) begin
                op = NET25[idx];
                lo = smp_min(v[op[9:5]], v[op[4:0]]);
                hi = smp_max(v[op[9:5]], v[op[4:0]]);
                unique case (op[11:10])
                    OP_CS: begin
                        v[op[9:5]] = lo;
                        v[op[4:0]] = hi;
                    end
                    OP_MIN: v[op[9:5]] = lo;
                    default: v[op[9:5]] = hi;
                endcase
            end
        end
        return v;
    endfunction

    function automatic t_nine sort3_at(t_nine vin, int b);
        t_nine v;
        t_smp  t;
        v = vin;
        if (v[b+1] > v[b+2]) begin
            t = v[b+1]; v[b+1] = v[b+2]; v[b+2] = t;
        end
        if (v[b] > v[b+1]) begin
            t = v[b]; v[b] = v[b+1]; v[b+1] = t;
        end
        if (v[b+1] > v[b+2]) begin
            t = v[b+1]; v[b+1] = v[b+2]; v[b+2] = t;
        end
        return v;
    endfunction

    function automatic t_nine nine_stage(t_nine vin, int stg);
        t_nine v;
        v = vin;
        if (stg == 0) begin
            v = sort3_at(sort3_at(sort3_at(v, 0), 3), 6);
        end else if (stg == 1) begin
            v[0] = smp_max(vin[0], smp_max(vin[3], vin[6]));
            v[1] = med3(vin[1], vin[4], vin[7]);
            v[2] = smp_min(vin[2], smp_min(vin[5], vin[8]));
        end else if (stg == 2) begin
            v[0] = med3(vin[0], vin[1], vin[2]);
        end
        return v;
    endfunction

endpackage

FILE: rtl/mf_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// Simple dual-port memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module mf_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/mf_front.sv
// ----------------------------------------------------------------------------
// Median filter front end
// Tracks row and column, keeps the line stores and the window, and queues
// each window that yields a result.
// ----------------------------------------------------------------------------
module mf_front #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_m5,
    input  logic [10:0]   i_row_width,
    input  logic          i_valid,
    output logic          o_ready,
    input  mf_pkg::t_pix  i_data,
    output logic          o_push,
    output mf_pkg::t_qent o_push_data,
    input  logic          i_full
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int WW = (CW > 11) ? CW : 11;
    localparam int SB = mf_pkg::SAMPLE_BITS;
    localparam logic [2:0] ROW_SAT = 3'd4;

    typedef struct packed {
        mf_pkg::t_smp px;
        logic [AW-1:0] col;
        logic          vld;
        logic          last;
        logic          m5;
    } t_s1;

    logic [CW-1:0] r_cc, n_cc, cc_a, cc_b;
    logic [2:0]    r_rc, n_rc, rc_a, rc_b;
    logic          r_s1_v;
    t_s1           r_s1, n_s1;
    logic          r_fwd;
    logic [4*SB-1:0] r_fwd_data;
    mf_pkg::t_win  r_win, n_win;
    logic [WW-1:0] w;
    logic [WW-1:0] need;
    logic [4*SB-1:0] ram_q, lines, new_word;
    logic          accept, retire;

    assign retire  = r_s1_v && (!r_s1.vld || !i_full);
    assign o_ready = !r_s1_v || retire;
    assign accept  = i_valid && o_ready;

    always_comb begin
        if (WW'(i_row_width) > WW'(MAX_WIDTH)) begin
            w = WW'(MAX_WIDTH);
        end else if (i_row_width == 11'd0) begin
            w = WW'(1);
        end else begin
            w = WW'(i_row_width);
        end
        need = i_m5 ? WW'(4) : WW'(2);
        cc_a = i_data.frame_start ? '0 : r_cc;
        rc_a = i_data.frame_start ? '0 : r_rc;
        cc_b = cc_a;
        rc_b = rc_a;
        if (WW'(cc_a) >= w) begin
            cc_b = '0;
            rc_b = (rc_a < ROW_SAT) ? rc_a + 3'd1 : rc_a;
        end
        n_s1.px   = i_data.pixel;
        n_s1.col  = cc_b[AW-1:0];
        n_s1.vld  = (WW'(cc_b) >= need) && (WW'(rc_b) >= need);
        n_s1.last = (WW'(cc_b) + WW'(1)) >= w;
        n_s1.m5   = i_m5;
        if (n_s1.last) begin
            n_cc = '0;
            n_rc = (rc_b < ROW_SAT) ? rc_b + 3'd1 : rc_b;
        end else begin
            n_cc = cc_b + CW'(1);
            n_rc = rc_b;
        end
    end

    assign lines    = r_fwd ? r_fwd_data : ram_q;
    assign new_word = {lines[3*SB-1:0], r_s1.px};

    always_comb begin
        for (int r = 0; r < 5; r++) begin
            for (int k = 0; k < 4; k++) begin
                n_win[r*5+k] = r_win[r*5+k+1];
            end
        end
        for (int r = 0; r < 4; r++) begin
            n_win[r*5+4] = lines[(3-r)*SB +: SB];
        end
        n_win[24] = r_s1.px;
    end

    mf_ram #(
        .WIDTH (4 * SB),
        .DEPTH (MAX_WIDTH)
    ) u_lines (
        .i_clk   (i_clk),
        .i_we    (retire),
        .i_waddr (r_s1.col),
        .i_wdata (new_word),
        .i_re    (accept),
        .i_raddr (n_s1.col),
        .o_rdata (ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cc   <= '0;
            r_rc   <= '0;
            r_s1_v <= 1'b0;
            r_fwd  <= 1'b0;
            r_win  <= '0;
        end else begin
            if (accept) begin
                r_cc   <= n_cc;
                r_rc   <= n_rc;
                r_s1   <= n_s1;
                r_fwd  <= retire && (n_s1.col == r_s1.col);
                r_fwd_data <= new_word;
            end
            if (accept) begin
                r_s1_v <= 1'b1;
            end else if (retire) begin
                r_s1_v <= 1'b0;
            end
            if (retire) begin
                r_win <= n_win;
            end
        end
    end

    assign o_push           = retire && r_s1.vld;
    assign o_push_data.win  = n_win;
    assign o_push_data.m5   = r_s1.m5;
    assign o_push_data.last = r_s1.last;

endmodule

FILE: rtl/mf_queue.sv
// ----------------------------------------------------------------------------
// Median filter window queue
// Four-entry queue of windows between the front end and the sorting network.
// ----------------------------------------------------------------------------
module mf_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  mf_pkg::t_qent  i_data,
    input  logic           i_pop,
    output mf_pkg::t_qent  o_data,
    output mf_pkg::t_qstat o_stat
);

    mf_pkg::t_qent r_mem [0:3];
    logic [1:0]    r_wp, r_rp;
    logic [2:0]    r_cnt;
    logic          full, empty, push, pop;

    assign full  = (r_cnt == 3'd4);
    assign empty = (r_cnt == 3'd0);
    assign push  = i_push && !full;
    assign pop   = i_pop && !empty;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_data;
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + 2'd1;
            end
            if (pop) begin
                r_rp <= r_rp + 2'd1;
            end
            r_cnt <= r_cnt + {2'b0, push} - {2'b0, pop};
        end
    end

    assign o_data       = r_mem[r_rp];
    assign o_stat.push  = i_push;
    assign o_stat.pop   = i_pop;
    assign o_stat.full  = full;
    assign o_stat.empty = empty;

endmodule

FILE: rtl/mf_back.sv
// ----------------------------------------------------------------------------
// Median filter back end
// Pipelined sorting networks for both window sizes and the output register.
// ----------------------------------------------------------------------------
module mf_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  mf_pkg::t_qent i_head,
    input  logic          i_empty,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_ready,
    output mf_pkg::t_res  o_data
);

    localparam int NS = mf_pkg::NET_STAGES;

    logic          r_v    [0:NS-1];
    mf_pkg::t_win  r_w25  [0:NS-1];
    mf_pkg::t_nine r_w9   [0:NS-1];
    logic          r_m5   [0:NS-1];
    logic          r_last [0:NS-1];
    logic          r_ov;
    mf_pkg::t_res  r_out;
    logic          adv;
    mf_pkg::t_nine head9;

    assign adv   = !r_ov || i_ready;
    assign o_pop = adv && !i_empty;

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                head9[r*3+c] = i_head.win[(r+2)*5+c+2];
            end
        end
    end

    for (genvar k = 0; k < NS; k++) begin : g_stage
        if (k == 0) begin : g_head
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[k] <= 1'b0;
                end else if (adv) begin
                    r_v[k] <= !i_empty;
                end
                if (adv) begin
                    r_w25[k]  <= mf_pkg::net25_stage(i_head.win, k);
                    r_w9[k]   <= mf_pkg::nine_stage(head9, k);
                    r_m5[k]   <= i_head.m5;
                    r_last[k] <= i_head.last;
                end
            end
        end else begin : g_body
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[k] <= 1'b0;
                end else if (adv) begin
                    r_v[k] <= r_v[k-1];
                end
                if (adv) begin
                    r_w25[k]  <= mf_pkg::net25_stage(r_w25[k-1], k);
                    r_w9[k]   <= mf_pkg::nine_stage(r_w9[k-1], k);
                    r_m5[k]   <= r_m5[k-1];
                    r_last[k] <= r_last[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (adv) begin
            r_ov <= r_v[NS-1];
        end
        if (adv) begin
            r_out.median  <= r_m5[NS-1]
                ? mf_pkg::smp_max(r_w25[NS-1][10], r_w25[NS-1][12])
                : r_w9[NS-1][0];
            r_out.row_end <= r_last[NS-1];
        end
    end

    assign o_valid = r_ov;
    assign o_data  = r_out;

endmodule

FILE: rtl/median_filter_3x3_5x5.sv
// ----------------------------------------------------------------------------
// Median filter, 3x3 or 5x5 window
// Streaming median filter over signed samples in raster order.
//
//   Channel   Direction  Handshake                        Payload
//   input     in         i_in_valid / o_in_ready          i_in_data (t_pix)
//   output    out        o_out_valid / i_out_ready        o_out_data (t_res)
//   config    in         psel, penable, pwrite, pready    paddr, pwdata, prdata
//
// One pixel is accepted per cycle while the window queue has room. The line
// store is read as the pixel is registered, and the sorting network is 25
// stages deep. Reset clears counts, window and control state. A stalled
// output fills the four-entry window queue before the input stalls.
// ----------------------------------------------------------------------------
module median_filter_3x3_5x5 #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    output logic         o_in_ready,
    input  mf_pkg::t_pix i_in_data,
    output logic         o_out_valid,
    input  logic         i_out_ready,
    output mf_pkg::t_res o_out_data,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    logic           r_mask_sel;
    logic [10:0]    r_row_width;
    logic           push, pop;
    mf_pkg::t_qent  push_data, head;
    mf_pkg::t_qstat q_stat;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask_sel  <= 1'b0;
            r_row_width <= 11'd1024;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[2])
                mf_pkg::REG_IDX_MASK:  r_mask_sel  <= pwdata[0];
                mf_pkg::REG_IDX_WIDTH: r_row_width <= pwdata[10:0];
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            mf_pkg::REG_IDX_MASK:  prdata = {31'd0, r_mask_sel};
            mf_pkg::REG_IDX_WIDTH: prdata = {21'd0, r_row_width};
        endcase
    end

    mf_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_m5        (r_mask_sel),
        .i_row_width (r_row_width),
        .i_valid     (i_in_valid),
        .o_ready     (o_in_ready),
        .i_data      (i_in_data),
        .o_push      (push),
        .o_push_data (push_data),
        .i_full      (q_stat.full)
    );

    mf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .i_pop   (pop),
        .o_data  (head),
        .o_stat  (q_stat)
    );

    mf_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .i_empty (q_stat.empty),
        .o_pop   (pop),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data)
    );

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_stat.push |-> !q_stat.full)
        else $error("window queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_stat.pop |-> !q_stat.empty)
        else $error("window queue read while empty");

    a_stall_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |-> !pop)
        else $error("queue read while output stalled");

endmodule

FILE: test/median_filter_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Median filter checker
// Watches the pixel, result and register ports of the median filter, keeps
// its own copy of the line stores, window and counts, predicts each result
// as the true median of the window and compares it with what the block gives.
// ----------------------------------------------------------------------------
module median_filter_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    input  logic         i_in_ready,
    input  mf_pkg::t_pix i_in_data,
    input  logic         i_out_valid,
    input  logic         i_out_ready,
    input  mf_pkg::t_res i_out_data,
    input  logic         i_psel,
    input  logic         i_penable,
    input  logic         i_pwrite,
    input  logic         i_pready,
    input  logic [2:0]   i_paddr,
    input  logic [31:0]  i_pwdata,
    output int           o_errors,
    output int           o_pending,
    output int           o_pixels,
    output int           o_medians,
    output logic         o_moved
);

    mf_pkg::t_smp line_mem [4][1024];
    mf_pkg::t_smp nbhd [25];
    int unsigned  col_cnt;
    int unsigned  row_cnt;
    logic         win5;
    logic [10:0]  row_len;
    mf_pkg::t_res medians_due [$];

    function automatic mf_pkg::t_smp window_median(logic five);
        mf_pkg::t_smp s [25];
        mf_pkg::t_smp t;
        int           n;
        int           j;
        n = five ? 25 : 9;
        for (int i = 0; i < n; i++) begin
            s[i] = five ? nbhd[i] : nbhd[(i / 3 + 2) * 5 + (i % 3) + 2];
        end
        for (int i = 1; i < n; i++) begin
            t = s[i];
            j = i - 1;
            while (j >= 0 && s[j] > t) begin
                s[j + 1] = s[j];
                j--;
            end
            s[j + 1] = t;
        end
        return s[n / 2];
    endfunction

    task automatic predict_pixel(mf_pkg::t_pix px);
        int unsigned w;
        int unsigned need;
        logic        ok;
        logic        last;
        if (px.frame_start) begin
            col_cnt = 0;
            row_cnt = 0;
        end
        w = (row_len > 1024) ? 1024 : row_len;
        if (w == 0) w = 1;
        if (col_cnt >= w) begin
            col_cnt = 0;
            if (row_cnt < 4) row_cnt++;
        end
        for (int r = 0; r < 5; r++) begin
            for (int k = 0; k < 4; k++) nbhd[r * 5 + k] = nbhd[r * 5 + k + 1];
        end
        for (int r = 0; r < 4; r++) nbhd[r * 5 + 4] = line_mem[3 - r][col_cnt];
        nbhd[24] = px.pixel;
        for (int r = 3; r > 0; r--) line_mem[r][col_cnt] = line_mem[r - 1][col_cnt];
        line_mem[0][col_cnt] = px.pixel;
        need = win5 ? 4 : 2;
        ok   = (col_cnt >= need) && (row_cnt >= need);
        last = (col_cnt + 1 >= w);
        if (last) begin
            col_cnt = 0;
            if (row_cnt < 4) row_cnt++;
        end else begin
            col_cnt++;
        end
        if (ok) medians_due.push_back('{median: window_median(win5), row_end: last});
    endtask

    always @(posedge i_clk) begin
        mf_pkg::t_res exp_res;
        logic         moved_now;
        int           errs_now;
        moved_now = 1'b0;
        errs_now  = 0;
        if (!i_rst_n) begin
            for (int i = 0; i < 25; i++) nbhd[i] = '0;
            col_cnt = 0;
            row_cnt = 0;
            win5    = 1'b0;
            row_len = 11'd1024;
            medians_due.delete();
            o_errors  <= 0;
            o_pixels  <= 0;
            o_medians <= 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                moved_now = 1'b1;
                if (i_paddr[2] == mf_pkg::REG_IDX_MASK) win5 = i_pwdata[0];
                else row_len = i_pwdata[10:0];
            end
            if (i_in_valid && i_in_ready) begin
                moved_now = 1'b1;
                o_pixels <= o_pixels + 1;
                predict_pixel(i_in_data);
            end
            if (i_out_valid && i_out_ready) begin
                moved_now = 1'b1;
                o_medians <= o_medians + 1;
                if (medians_due.size() == 0) begin
                    $display("%0t: unexpected result, median %0d row_end %0b", $time,
                             i_out_data.median, i_out_data.row_end);
                    errs_now++;
                end else begin
                    exp_res = medians_due.pop_front();
                    if (exp_res.median !== i_out_data.median) begin
                        $display("%0t: median expected %0d, actual %0d", $time,
                                 exp_res.median, i_out_data.median);
                        errs_now++;
                    end
                    if (exp_res.row_end !== i_out_data.row_end) begin
                        $display("%0t: row_end expected %0b, actual %0b", $time,
                                 exp_res.row_end, i_out_data.row_end);
                        errs_now++;
                    end
                end
            end
            o_errors <= o_errors + errs_now;
        end
        o_moved   <= moved_now;
        o_pending <= medians_due.size();
    end

endmodule

FILE: test/tb_median_filter_3x3_5x5.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Median filter testbench
// Streams directed and random frames through the filter under both window
// sizes and several row widths, with idle and stall phases on both sides,
// and gives the verdict from the checker's mismatch count.
// ----------------------------------------------------------------------------
module tb_median_filter_3x3_5x5;

    localparam int WATCHDOG = 5000;

    logic         i_clk;
    logic         i_rst_n;
    logic         in_valid;
    logic         in_ready;
    mf_pkg::t_pix in_data;
    logic         out_valid;
    logic         out_ready = 1'b1;
    mf_pkg::t_res out_data;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [2:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;
    int           errors;
    int           pending;
    int           pixels;
    int           medians;
    logic         moved;
    int           send_idle;
    int           recv_stall;
    logic         hold_off;
    logic         hold_done = 1'b0;
    int           quiet;

    median_filter_3x3_5x5 u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    median_filter_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in_data   (in_data),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out_data  (out_data),
        .i_psel      (psel),
        .i_penable   (penable),
        .i_pwrite    (pwrite),
        .i_pready    (pready),
        .i_paddr     (paddr),
        .i_pwdata    (pwdata),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_pixels    (pixels),
        .o_medians   (medians),
        .o_moved     (moved)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (hold_off && !hold_done) begin
            out_ready <= 1'b0;
            repeat (200) @(posedge i_clk);
            hold_done <= 1'b1;
        end else begin
            out_ready <= ($urandom_range(99) >= recv_stall);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || moved) begin
            quiet <= 0;
        end else if (quiet >= WATCHDOG) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    task automatic send_pixel(input mf_pkg::t_smp px, input logic fs);
        logic taken;
        while ($urandom_range(99) < send_idle) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{pixel: px, frame_start: fs};
        do begin
            @(negedge i_clk);
            taken = in_ready;
            @(posedge i_clk);
        end while (!taken);
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic mf_pkg::t_smp rand_pixel();
        unique case ($urandom_range(9))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return mf_pkg::t_smp'($urandom_range(7)) - 16'sd4;
            default: return mf_pkg::t_smp'($urandom);
        endcase
    endfunction

    task automatic random_phase(input logic m5, input logic [10:0] width, input int count,
                                input int idle_pct, input int stall_pct);
        drain();
        write_reg(mf_pkg::REG_IDX_MASK, {31'd0, m5});
        write_reg(mf_pkg::REG_IDX_WIDTH, {21'd0, width});
        send_idle  = idle_pct;
        recv_stall = stall_pct;
        for (int i = 0; i < count; i++) begin
            send_pixel(rand_pixel(), (i == 0) || ($urandom_range(79) == 0));
        end
    endtask

    initial begin
        mf_pkg::t_smp edge_vals [6] = '{16'sh8000, 16'sh7FFF, 16'sd0, -16'sd1, 16'sd1,
                                        16'sh4000};
        i_rst_n    = 1'b0;
        in_valid   = 1'b0;
        in_data    = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        send_idle  = 0;
        recv_stall = 0;
        hold_off   = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_reg(mf_pkg::REG_IDX_WIDTH, 32'd5);
        for (int i = 0; i < 25; i++) send_pixel(edge_vals[(i * 7 + i / 5) % 6], i == 0);
        drain();
        write_reg(mf_pkg::REG_IDX_MASK, 32'd1);
        for (int i = 0; i < 25; i++) send_pixel(edge_vals[(i * 5 + i / 3) % 6], i == 0);

        drain();
        hold_off <= 1'b1;
        random_phase(1'b0, 11'd7, 50, 0, 0);
        drain();
        random_phase(1'b1, 11'd6, 50, 87, 0);
        random_phase(1'b0, 11'd13, 50, 0, 87);
        random_phase(1'b1, 11'd9, 50, 30, 30);
        random_phase(1'b1, 11'd5, 40, 0, 0);
        random_phase(1'b0, 11'd0, 20, 0, 0);
        random_phase(1'b1, 11'd11, 60, 30, 30);
        random_phase(1'b0, 11'd2047, 40, 0, 0);
        drain();

        $display("Pixels accepted: %0d, medians checked: %0d", pixels, medians);
        $display("Covered 3x3 and 5x5 windows, row widths 0 to 2047, idle and stall phases.");
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
